/* rtl/palette_nearest_color_search_defines.svh */
// Assertion macros shared by the checker.
`ifndef PALETTE_NEAREST_COLOR_SEARCH_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_DEFINES_SVH
`define PNC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PNC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

/* rtl/pncs_pkg.sv */
// ---------------------------------------------------------------------------
// pncs_pkg
// Shared types and constants of the nearest palette color search.
// ---------------------------------------------------------------------------
package pncs_pkg;
    localparam int PNCS_ENTRIES = 256;
    localparam int COLOR_W = 8;
    localparam int DIST_W = 18;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } pncs_state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, 3'b100};
    endfunction
endpackage

/* rtl/pncs_cell.sv */
// ---------------------------------------------------------------------------
// pncs_cell
// One palette entry: holds its color and shifts it to its neighbor during a
// search so that the chain rotates once per query.
// ---------------------------------------------------------------------------
module pncs_cell
    import pncs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load_en,
    input  rgb_t load_color,
    input  logic shift_en,
    input  rgb_t shift_in,
    output rgb_t color
);
    rgb_t color_reg;
    rgb_t color_next;

    always_comb
    begin
        color_next = color_reg;
        if (load_en)
        begin
            color_next = load_color;
        end
        else if (shift_en)
        begin
            color_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;
endmodule

/* rtl/pncs_dist.sv */
// ---------------------------------------------------------------------------
// pncs_dist
// Squared RGB distance between the query color and the chain head, with a
// register after the squares.
// ---------------------------------------------------------------------------
module pncs_dist
    import pncs_pkg::*;
(
    input  logic clk,
    input  rgb_t query,
    input  rgb_t entry,
    output logic [DIST_W-1:0] sq_dist
);
    logic [7:0] dr, dg, db;
    logic [15:0] sr_reg, sg_reg, sb_reg;

    assign dr = (query.r > entry.r) ? query.r - entry.r : entry.r - query.r;
    assign dg = (query.g > entry.g) ? query.g - entry.g : entry.g - query.g;
    assign db = (query.b > entry.b) ? query.b - entry.b : entry.b - query.b;

    always_ff @(posedge clk)
    begin
        sr_reg <= 16'(dr) * 16'(dr);
        sg_reg <= 16'(dg) * 16'(dg);
        sb_reg <= 16'(db) * 16'(db);
    end

    assign sq_dist = DIST_W'(sr_reg) + DIST_W'(sg_reg) + DIST_W'(sb_reg);
endmodule

/* rtl/palette_nearest_color_search.sv */
// ---------------------------------------------------------------------------
// palette_nearest_color_search
// Nearest palette color search over a rotating chain of entry cells.
// ---------------------------------------------------------------------------
// One input channel (in_valid/in_stall) carries load and query items and one
// output channel (out_valid/out_stall) carries one result item per input.
// A load writes its entry into the chain, passes through ST_DONE and then
// raises out_valid. A query rotates the chain once past a distance unit
// that registers its squares, and the search then passes through ST_DONE
// before out_valid rises. One item is worked at a time and the next item
// can be accepted in the cycle after the result is taken. The result waits
// in its register while out_stall is high. Reset clears every entry to
// black and empties the block.
// ---------------------------------------------------------------------------
module palette_nearest_color_search
    import pncs_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PNCS_ENTRIES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic req_type,
    input  logic [7:0] entry_index,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [14:0] color_code,
    output logic out_valid,
    input  logic out_stall,
    output logic [31:0] packed_color,
    output logic [7:0] nearest_index,
    output logic [DIST_W-1:0] best_distance
);
    localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CW = $clog2(PALETTE_ENTRIES + 2);

    pncs_state_t state_reg, state_next;
    rgb_t cell_color [PALETTE_ENTRIES];
    rgb_t query_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0] best_idx_reg, best_idx_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [31:0] pack_reg;
    logic out_valid_reg;
    logic [DIST_W-1:0] sq_dist;
    logic accept, shift_en, load_ok, done_q;
    logic [CW-1:0] cmp_idx;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign shift_en = (state_reg == ST_SEARCH) && (cnt_reg < CW'(PALETTE_ENTRIES));
    assign load_ok = accept && (req_type == REQ_LOAD)
                     && ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
    assign cmp_idx = cnt_reg - CW'(1);

    genvar i;
    generate
        for (i = 0; i < PALETTE_ENTRIES; i++)
        begin : g_cell
            pncs_cell u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .load_en(load_ok && (entry_index[IW-1:0] == IW'(i))),
                .load_color('{r: red, g: green, b: blue}),
                .shift_en(shift_en),
                .shift_in(cell_color[(i + 1) % PALETTE_ENTRIES]),
                .color(cell_color[i])
            );
        end
    endgenerate

    pncs_dist u_dist (
        .clk(clk),
        .query(query_reg),
        .entry(cell_color[0]),
        .sq_dist(sq_dist)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_QUERY) ? ST_SEARCH : ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == CW'(PALETTE_ENTRIES))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        best_idx_next = best_idx_reg;
        best_d_next = best_d_reg;
        done_q = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && req_type == REQ_LOAD)
                begin
                    best_idx_next = '0;
                    best_d_next = '0;
                end
            end
            ST_SEARCH:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg >= CW'(1))
                begin
                    if (cnt_reg == CW'(1) || sq_dist < best_d_reg)
                    begin
                        best_d_next = sq_dist;
                        best_idx_next = 8'(cmp_idx);
                    end
                end
                done_q = (cnt_reg == CW'(PALETTE_ENTRIES));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_d_reg <= best_d_next;
        if (accept)
        begin
            query_reg <= '{r: widen5(color_code[4:0]), g: widen5(color_code[9:5]),
                           b: widen5(color_code[14:10])};
            if (req_type == REQ_LOAD)
            begin
                pack_reg <= {(load_ok && entry_index == 8'(PALETTE_ENTRIES - 1))
                             ? 8'h00 : 8'hFF, blue, green, red};
            end
            else
            begin
                pack_reg <= '0;
            end
        end
        if (done_q)
        begin
            pack_reg <= '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign packed_color = pack_reg;
    assign nearest_index = best_idx_reg;
    assign best_distance = best_d_reg;
endmodule

/* rtl/pncs_checker.sv */
// ---------------------------------------------------------------------------
// pncs_checker
// Port-level checks on the nearest palette color search.
// ---------------------------------------------------------------------------
`include "palette_nearest_color_search_defines.svh"
module pncs_checker
    import pncs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic req_type,
    input logic out_valid,
    input logic out_stall,
    input logic [31:0] packed_color,
    input logic [7:0] nearest_index,
    input logic [DIST_W-1:0] best_distance
);
    `PNC_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid |-> in_stall)
    `PNC_ASSERT_NEXT(a_load_lat, clk, rst_n, in_valid && !in_stall && req_type == REQ_LOAD,
        !out_valid)
    `PNC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(packed_color) && $stable(nearest_index) && $stable(best_distance))
    `PNC_ASSERT_IMPL(a_load_zero, clk, rst_n,
        (out_valid && packed_color[31:24] != 8'h0) |-> (best_distance == '0))
endmodule

bind palette_nearest_color_search pncs_checker u_pncs_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
    .packed_color(packed_color), .nearest_index(nearest_index),
    .best_distance(best_distance)
);

/* dv/palette_nearest_color_search_test.sv */
// ---------------------------------------------------------------------------
// Nearest palette color search testbench
// Loads palette entries and sends color queries, in some tests with random
// gaps on both sides. The expected packed words, indexes and distances are computed
// from a local copy of the palette and compared with every result item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_nearest_color_search_test;
    import pncs_pkg::*;

    typedef struct {
        logic [31:0] packed_color;
        logic [7:0] nearest_index;
        logic [DIST_W-1:0] best_distance;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = REQ_LOAD;
    logic [7:0] entry_index = '0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic [14:0] color_code = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] packed_color;
    logic [7:0] nearest_index;
    logic [DIST_W-1:0] best_distance;

    rgb_t palette_copy [PNCS_ENTRIES];
    answer_t answer_queue [$];
    int error_count = 0;
    int cycle_count = 0;
    int hold_off_cycles = 0;
    bit random_stall = 1'b0;

    palette_nearest_color_search i_dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic int unsigned square_diff(int unsigned a, int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic send_item(logic kind, logic [7:0] idx, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b, logic [14:0] code);
        answer_t ans;
        int unsigned qr;
        int unsigned qg;
        int unsigned qb;
        int unsigned d;
        int gap;
        gap = random_stall ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ans = '{default: '0};
        if (kind == REQ_LOAD)
        begin
            palette_copy[idx] = '{r: r, g: g, b: b};
            ans.packed_color = {(idx == PNCS_ENTRIES - 1) ? 8'h00 : 8'hFF, b, g, r};
        end
        else
        begin
            qr = 32'({code[4:0], 3'b100});
            qg = 32'({code[9:5], 3'b100});
            qb = 32'({code[14:10], 3'b100});
            for (int v = 0; v < PNCS_ENTRIES; v++)
            begin
                d = square_diff(qr, 32'(palette_copy[v].r))
                    + square_diff(qg, 32'(palette_copy[v].g))
                    + square_diff(qb, 32'(palette_copy[v].b));
                if (v == 0 || d < 32'(ans.best_distance))
                begin
                    ans.best_distance = DIST_W'(d);
                    ans.nearest_index = 8'(v);
                end
            end
        end
        in_valid <= 1'b1;
        req_type <= kind;
        entry_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        color_code <= code;
        answer_queue.push_back(ans);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_load(logic [7:0] idx, logic [23:0] rgb);
        send_item(REQ_LOAD, idx, rgb[7:0], rgb[15:8], rgb[23:16], 15'($urandom));
    endtask

    task automatic send_query(logic [14:0] code);
        send_item(REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), code);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (answer_queue.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic test_directed();
        send_query(15'h0000);
        send_query(15'h7FFF);
        send_load(8'd0, 24'hFFFFFF);
        send_load(8'd255, 24'h000000);
        send_load(8'd255, 24'hFFFFFF);
        send_load(8'd128, 24'h0000FF);
        send_load(8'd7, 24'h00FF00);
        send_load(8'd9, 24'hFF0000);
        send_load(8'd12, 24'hFF0000);
        send_query(15'h001F);
        send_query(15'h03E0);
        send_query(15'h7C00);
        send_query(15'h7FFF);
        send_query(15'h0000);
        send_query(15'h5555);
        send_query(15'h2AAA);
    endtask

    task automatic test_full_palette();
        for (int i = 0; i < PNCS_ENTRIES; i++)
            send_load(i[7:0], 24'($urandom));
        for (int i = 0; i < 200; i++)
            send_query(15'($urandom));
    endtask

    task automatic test_random_mix();
        for (int i = 0; i < 1000; i++)
            if ($urandom_range(0, 2) == 0)
                send_load(8'($urandom), $urandom_range(0, 7) == 0 ? 24'h0 : 24'($urandom));
            else
                send_query(15'($urandom));
    endtask

    task automatic test_stalled_output();
        hold_off_cycles = 600;
        for (int i = 0; i < 40; i++)
            if (i[0])
                send_load(8'($urandom), 24'($urandom));
            else
                send_query(15'($urandom));
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= random_stall ? ($urandom_range(0, 3) == 0) : 1'b0;
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answer_queue.size() == 0)
            begin
                report_mismatch("unexpected result item", 64'(1), 64'(0));
            end
            else
            begin
                want = answer_queue.pop_front();
                if (packed_color !== want.packed_color)
                    report_mismatch("packed_color", 64'(packed_color),
                                    64'(want.packed_color));
                if (nearest_index !== want.nearest_index)
                    report_mismatch("nearest_index", 64'(nearest_index),
                                    64'(want.nearest_index));
                if (best_distance !== want.best_distance)
                    report_mismatch("best_distance", 64'(best_distance),
                                    64'(want.best_distance));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < PNCS_ENTRIES; i++)
            palette_copy[i] = '{r: 8'h00, g: 8'h00, b: 8'h00};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        random_stall = 1'b1;
        test_full_palette();
        random_stall = 1'b0;
        test_stalled_output();
        random_stall = 1'b1;
        test_random_mix();
        test_stalled_output();
        wait_drained();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/pncs_pkg.sv
rtl/pncs_cell.sv
rtl/pncs_dist.sv
rtl/palette_nearest_color_search.sv
rtl/pncs_checker.sv
dv/palette_nearest_color_search_test.sv
